// File: rtl/sllcn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sllcn_pkg
// Shared types and constants for the sensor link change notice queue.
// ----------------------------------------------------------------------------
package sllcn_pkg;

  // action field codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  // notice kind codes
  localparam logic KIND_CONN = 1'b0;
  localparam logic KIND_DISC = 1'b1;

  localparam int          HOLD_W     = 16;
  localparam int          TIME_W     = 32;
  localparam logic [15:0] HOLD_RESET = 16'd1500;

  localparam int IN_DATA_W  = 40;  // 36 used bits, padded to bytes
  localparam int OUT_DATA_W = 8;   // 4 used bits, padded to a byte

  // notice code: sensor in bit 1, kind in bit 0
  typedef logic [1:0] notice_code_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic execute;  // update state, load result register
  } ctrl_cmd_t;

endpackage

// File: rtl/sllcn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sllcn_ctrl
// Request sequencer: accept, execute, then hold the result until taken.
// ----------------------------------------------------------------------------
module sllcn_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output sllcn_pkg::ctrl_cmd_t cmd
);
  import sllcn_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (m_tready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready    = (state == ST_IDLE);
  assign m_tvalid    = (state == ST_OUT);
  assign cmd.capture = (state == ST_IDLE) && s_tvalid;
  assign cmd.execute = (state == ST_EXEC);

endmodule

// File: rtl/sllcn_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sllcn_dpath
// Sensor link tracking, notice queue, active notice and result register.
// ----------------------------------------------------------------------------
module sllcn_dpath #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sllcn_pkg::ctrl_cmd_t  cmd,
  input  logic                  cfg_wr_en,
  input  logic [15:0]           cfg_wr_data,
  input  logic                  in_action,
  input  logic [1:0]            in_sensor_code,
  input  logic                  in_connected,
  input  logic                  in_blocked,
  input  logic [31:0]           in_now_ms,
  output logic                  redraw_request,
  output logic                  notice_active,
  output logic                  shown_sensor,
  output logic                  shown_kind
);
  import sllcn_pkg::*;

  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int CW = HW + 1;  // head/fill arithmetic width

  // configuration
  logic [HOLD_W-1:0] hold_time_ms;

  // captured request
  logic              act;
  logic [1:0]        sensor_code;
  logic              conn;
  logic              blk;
  logic [TIME_W-1:0] now_ms;

  // link state
  logic [1:0] seen_flags;
  logic [1:0] last_connected;

  // queue
  notice_code_t       notice_slots [QUEUE_DEPTH];
  logic [HW-1:0]      queue_head;
  logic [FW-1:0]      queue_fill;

  // active notice
  logic              active_flag;
  logic              active_sensor_reg;
  logic              active_kind_reg;
  logic [TIME_W-1:0] deadline_ms;

  // combinational
  logic              sensor_idx;
  notice_code_t      new_code;
  logic              is_change;
  logic              dup;
  logic              push;
  logic              expire;
  logic              pop;
  logic              active_after;
  logic [TIME_W-1:0] diff;
  logic [TIME_W-1:0] deadline_new;
  logic [CW-1:0]     tail_sum;
  logic [HW-1:0]     tail_idx;
  logic [HW-1:0]     head_inc;
  notice_code_t      head_code;
  logic [CW-1:0]     off [QUEUE_DEPTH];

  assign sensor_idx = sensor_code[0];
  assign new_code   = {sensor_idx, conn ? KIND_CONN : KIND_DISC};
  assign is_change  = (act == ACT_SAMPLE) && !sensor_code[1] &&
                      seen_flags[sensor_idx] && (conn != last_connected[sensor_idx]);

  // duplicate check: active notice plus every filled slot, in parallel
  always_comb begin
    dup = active_flag && ({active_sensor_reg, active_kind_reg} == new_code);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      off[i] = CW'(i) + CW'(QUEUE_DEPTH) - {1'b0, queue_head};
      if (off[i] >= CW'(QUEUE_DEPTH)) off[i] = off[i] - CW'(QUEUE_DEPTH);
      if ((off[i] < CW'(queue_fill)) && (notice_slots[i] == new_code)) dup = 1'b1;
    end
  end

  assign push = is_change && (queue_fill < FW'(QUEUE_DEPTH)) && !dup;

  always_comb begin
    tail_sum = {1'b0, queue_head} + CW'(queue_fill);
    if (tail_sum >= CW'(QUEUE_DEPTH)) tail_sum = tail_sum - CW'(QUEUE_DEPTH);
    tail_idx = tail_sum[HW-1:0];
  end

  assign head_inc  = (queue_head == HW'(QUEUE_DEPTH - 1)) ? '0 : queue_head + 1'b1;
  assign head_code = notice_slots[queue_head];

  // service tick: expiry uses wrapped signed difference
  assign diff         = now_ms - deadline_ms;
  assign deadline_new = now_ms + TIME_W'(hold_time_ms);
  assign expire       = (act == ACT_TICK) && !blk && active_flag && !diff[TIME_W-1];
  assign active_after = active_flag && !expire;
  assign pop          = (act == ACT_TICK) && !blk && !active_after && (queue_fill != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time_ms <= HOLD_RESET;
    end else if (cfg_wr_en) begin
      hold_time_ms <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act         <= in_action;
      sensor_code <= in_sensor_code;
      conn        <= in_connected;
      blk         <= in_blocked;
      now_ms      <= in_now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && push) begin
      notice_slots[tail_idx] <= new_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_flags        <= '0;
      last_connected    <= '0;
      queue_head        <= '0;
      queue_fill        <= '0;
      active_flag       <= 1'b0;
      active_sensor_reg <= 1'b0;
      active_kind_reg   <= 1'b0;
      deadline_ms       <= '0;
    end else if (cmd.execute) begin
      if (act == ACT_SAMPLE) begin
        if (!sensor_code[1]) begin
          seen_flags[sensor_idx]     <= 1'b1;
          last_connected[sensor_idx] <= conn;
        end
        if (push) queue_fill <= queue_fill + 1'b1;
      end else if (blk) begin
        if (active_flag) deadline_ms <= deadline_new;
      end else begin
        if (expire) active_flag <= 1'b0;
        if (pop) begin
          queue_head        <= head_inc;
          queue_fill        <= queue_fill - 1'b1;
          active_flag       <= 1'b1;
          active_sensor_reg <= head_code[1];
          active_kind_reg   <= head_code[0];
          deadline_ms       <= deadline_new;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (act == ACT_SAMPLE) begin
        redraw_request <= push;
        notice_active  <= active_flag;
        shown_sensor   <= active_flag & active_sensor_reg;
        shown_kind     <= active_flag & active_kind_reg;
      end else if (blk) begin
        redraw_request <= 1'b0;
        notice_active  <= active_flag;
        shown_sensor   <= active_flag & active_sensor_reg;
        shown_kind     <= active_flag & active_kind_reg;
      end else if (pop) begin
        redraw_request <= 1'b1;
        notice_active  <= 1'b1;
        shown_sensor   <= head_code[1];
        shown_kind     <= head_code[0];
      end else begin
        redraw_request <= expire;
        notice_active  <= active_after;
        shown_sensor   <= active_after & active_sensor_reg;
        shown_kind     <= active_after & active_kind_reg;
      end
    end
  end

endmodule

// File: rtl/sensor_link_change_notice_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_link_change_notice_queue
// Tracks two sensor links and queues connect/disconnect screen notices.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_* stream. tuser selects the kind: a sensor
//   sample (sensor code + connected bit) or a service tick (blocked bit +
//   millisecond time). Each request yields exactly one result on m_*:
//   redraw request, notice active, shown sensor and shown kind.
//   hold_time_ms is written through cfg_wr_en/cfg_wr_data while idle.
// Timing:
//   A request is captured when accepted, the EXEC state updates the state
//   and loads the result register, and m_tvalid is raised in the OUT state.
//   One request is in flight at a time: accept, execute, then the result
//   is held until m_tready; a new request is taken only after that.
// Reset:
//   rst (synchronous) clears links, queue and active notice, sets the
//   hold time to 1500 ms. Queue slots are not cleared; only filled ones
//   are ever read.
// Stall:
//   While m_tready is low the result holds and s_tready stays low.
// ----------------------------------------------------------------------------
module sensor_link_change_notice_queue #(
  parameter int QUEUE_DEPTH = 4  // 1 to 16 pending notices
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // sensor_code[1:0], connected[2], blocked[3], now_ms[35:4]
  input  logic        s_tuser,   // action: 0 sample, 1 service tick
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // redraw_request[0], notice_active[1],
                                 // shown_sensor[2], shown_kind[3]
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data  // hold_time_ms
);
  import sllcn_pkg::*;

  ctrl_cmd_t cmd;
  logic      redraw_request;
  logic      notice_active;
  logic      shown_sensor;
  logic      shown_kind;

  // controller: handshake and command sequencing
  sllcn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // datapath: link state, queue, active notice, result register
  sllcn_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_action      (s_tuser),
    .in_sensor_code (s_tdata[1:0]),
    .in_connected   (s_tdata[2]),
    .in_blocked     (s_tdata[3]),
    .in_now_ms      (s_tdata[35:4]),
    .redraw_request (redraw_request),
    .notice_active  (notice_active),
    .shown_sensor   (shown_sensor),
    .shown_kind     (shown_kind)
  );

  assign m_tdata = {4'b0000, shown_kind, shown_sensor, notice_active, redraw_request};

  // one request in flight: never taking input while a result is shown
  assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input accepted while result pending");

  // every accepted request produces a result once it has passed the execute state
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> ##1 m_tvalid)
    else $error("result missing after accepted request");

  // no shown notice means zero sensor and kind
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[1]) |-> (m_tdata[3:2] == 2'b00))
    else $error("notice fields set without active notice");

endmodule

// File: verif/link_notice_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_notice_checker
// Watches the request and result streams of the notice queue. It keeps its own
// copy of link, queue and display state, predicts each result and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module link_notice_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [sllcn_pkg::IN_DATA_W-1:0]  s_tdata,   // sensor_code[1:0], connected[2],
                                                      // blocked[3], now_ms[35:4]
  input  logic                             s_tuser,   // action
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [sllcn_pkg::OUT_DATA_W-1:0] m_tdata,   // redraw_request[0], notice_active[1],
                                                      // shown_sensor[2], shown_kind[3]
  input  logic                             cfg_wr_en,
  input  logic [sllcn_pkg::HOLD_W-1:0]     cfg_wr_data,
  output int                               mismatch_total,
  output int                               in_flight
);
  import sllcn_pkg::*;

  localparam int DEPTH = 4;

  // redraw in bit 0, as on m_tdata
  typedef struct packed {
    logic kind;
    logic sensor;
    logic active;
    logic redraw;
  } notice_result_t;

  logic [HOLD_W-1:0] hold_ms;
  logic [1:0]        seen;
  logic [1:0]        last_conn;
  notice_code_t      slots [DEPTH];
  int                head;
  int                fill;
  logic              shown;
  logic              shown_sensor;
  logic              shown_kind;
  logic [TIME_W-1:0] deadline;
  notice_result_t    expected_notices [$];
  int                errors = 0;

  // same notice already on screen or waiting
  function automatic logic is_pending(notice_code_t code);
    if (shown && {shown_sensor, shown_kind} == code) return 1'b1;
    for (int i = 0; i < fill; i++)
      if (slots[(head + i) % DEPTH] == code) return 1'b1;
    return 1'b0;
  endfunction

  function automatic notice_result_t apply_link_event(logic act, logic [1:0] sensor,
                                                      logic conn, logic blk,
                                                      logic [TIME_W-1:0] now);
    notice_result_t    res;
    notice_code_t      code;
    logic [TIME_W-1:0] age;
    res = '0;
    if (act == ACT_SAMPLE) begin
      // codes 2 and 3 are untracked
      if (sensor[1] == 1'b0) begin
        if (!seen[sensor[0]]) begin
          seen[sensor[0]] = 1'b1;
          last_conn[sensor[0]] = conn;
        end else if (conn != last_conn[sensor[0]]) begin
          code = {sensor[0], conn ? KIND_CONN : KIND_DISC};
          if (fill < DEPTH && !is_pending(code)) begin
            slots[(head + fill) % DEPTH] = code;
            fill++;
            res.redraw = 1'b1;
          end
          last_conn[sensor[0]] = conn;
        end
      end
    end else if (blk) begin
      if (shown) deadline = now + hold_ms;
    end else begin
      age = now - deadline;
      if (shown && !age[TIME_W-1]) begin
        shown = 1'b0;
        res.redraw = 1'b1;
      end
      if (!shown && fill > 0) begin
        code = slots[head];
        head = (head + 1) % DEPTH;
        fill--;
        shown = 1'b1;
        shown_sensor = code[1];
        shown_kind = code[0];
        deadline = now + hold_ms;
        res.redraw = 1'b1;
      end
    end
    res.active = shown;
    res.sensor = shown & shown_sensor;
    res.kind = shown & shown_kind;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    notice_result_t got;
    notice_result_t want;
    if (rst) begin
      hold_ms = HOLD_RESET;
      seen = '0;
      last_conn = '0;
      head = 0;
      fill = 0;
      shown = 1'b0;
      shown_sensor = 1'b0;
      shown_kind = KIND_CONN;
      deadline = '0;
      expected_notices.delete();
    end else begin
      if (cfg_wr_en) hold_ms = cfg_wr_data;
      if (s_tvalid && s_tready)
        expected_notices.push_back(apply_link_event(s_tuser, s_tdata[1:0], s_tdata[2],
                                                    s_tdata[3], s_tdata[35:4]));
      if (m_tvalid && m_tready) begin
        got = m_tdata[3:0];
        if (expected_notices.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: unexpected result %b", $realtime, got);
        end else begin
          want = expected_notices.pop_front();
          if (got.redraw !== want.redraw || got.active !== want.active ||
              got.sensor !== want.sensor || got.kind !== want.kind) begin
            errors++;
            if (errors <= 10)
              $display("%0t: result mismatch redraw/active/sensor/kind exp %b%b%b%b got %b%b%b%b",
                       $realtime, want.redraw, want.active, want.sensor, want.kind,
                       got.redraw, got.active, got.sensor, got.kind);
          end
        end
      end
    end
    mismatch_total <= errors;
    in_flight <= expected_notices.size();
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sensor samples and service ticks into the notice queue, with random
// gaps on the request side and random stalls on the result side. A checker
// beside the block predicts every result; this module makes the stimulus,
// moves the hold time between phases and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import sllcn_pkg::*;

  localparam logic [1:0] SENSOR_SOIL    = 2'd0;
  localparam logic [1:0] SENSOR_PROBE   = 2'd1;
  localparam logic [1:0] SENSOR_SPARE_A = 2'd2;
  localparam logic [1:0] SENSOR_SPARE_B = 2'd3;

  localparam int PHASE_ITEMS = 235;
  // watchdog limit, far above what a full run needs
  localparam int CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tuser = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tready = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [HOLD_W-1:0]     cfg_wr_data = '0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [OUT_DATA_W-1:0] m_tdata;

  int                mismatch_total;
  int                in_flight;
  int                send_idle_pct = 9;
  int                recv_idle_pct = 79;
  int                cycle_count = 0;
  logic [HOLD_W-1:0] hold_now = HOLD_RESET;
  logic [TIME_W-1:0] clock_ms = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sensor_link_change_notice_queue #(
    .QUEUE_DEPTH(4)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  link_notice_checker notice_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .mismatch_total(mismatch_total),
    .in_flight     (in_flight)
  );

  // result side: stall at random at the current rate
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // One request. Called at a rising edge; returns at the edge where it was
  // taken. Random gaps go in front of it, so valid only drops when we idle.
  task automatic send_request(input logic act, input logic [1:0] sensor, input logic conn,
                              input logic blk, input logic [TIME_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {4'b0000, now, blk, conn, sensor};
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop requests and wait until every predicted result has come back.
  // The first edge lets the checker count the last request.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_hold(input logic [HOLD_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    hold_now = value;
  endtask

  // Random traffic: samples toggle the links about half the time, so notices
  // pile up and duplicates get dropped; ticks walk the clock in steps scaled
  // to the hold time, so notices expire, get extended and get replaced.
  task automatic run_random_phase(input int count);
    logic [1:0] sensor;
    logic       conn;
    logic       blk;
    int         pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      sensor = 2'($urandom_range(3));
      conn = 1'($urandom_range(1));
      blk = 1'($urandom_range(1));
      if (pick < 45) begin
        // untracked sensor codes now and then
        if ($urandom_range(9) != 0) sensor[1] = 1'b0;
        send_request(ACT_SAMPLE, sensor, conn, blk, $urandom);
      end else begin
        pick = $urandom_range(99);
        if (pick < 5) clock_ms = $urandom;  // jump anywhere, wraps included
        else if (pick < 50) clock_ms += $urandom_range(hold_now / 2);
        else clock_ms += $urandom_range(2 * hold_now);
        send_request(ACT_TICK, sensor, conn, $urandom_range(4) == 0, clock_ms);
      end
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // --- directed, hold time at its reset value of 1500 ---
    // ticks with nothing shown, unused sample fields at their extremes
    send_request(ACT_TICK,   SENSOR_SPARE_B, 1'b1, 1'b0, 32'd0);
    send_request(ACT_TICK,   SENSOR_SPARE_B, 1'b1, 1'b1, 32'hFFFF_FFFF);
    // untracked sensors change nothing
    send_request(ACT_SAMPLE, SENSOR_SPARE_A, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_request(ACT_SAMPLE, SENSOR_SPARE_B, 1'b0, 1'b0, 32'd0);
    // first samples only set the baseline
    send_request(ACT_SAMPLE, SENSOR_SOIL,    1'b1, 1'b0, 32'd0);
    send_request(ACT_SAMPLE, SENSOR_PROBE,   1'b0, 1'b0, 32'd0);
    // fill the queue: soil disc, (no change), soil conn, (dup soil disc),
    // probe conn, probe disc, then a change that is both full and dup
    send_request(ACT_SAMPLE, SENSOR_SOIL,    1'b0, 1'b0, 32'd0);
    send_request(ACT_SAMPLE, SENSOR_SOIL,    1'b0, 1'b0, 32'd0);
    send_request(ACT_SAMPLE, SENSOR_SOIL,    1'b1, 1'b0, 32'd0);
    send_request(ACT_SAMPLE, SENSOR_SOIL,    1'b0, 1'b0, 32'd0);
    send_request(ACT_SAMPLE, SENSOR_PROBE,   1'b1, 1'b0, 32'd0);
    send_request(ACT_SAMPLE, SENSOR_PROBE,   1'b0, 1'b0, 32'd0);
    send_request(ACT_SAMPLE, SENSOR_SOIL,    1'b1, 1'b1, 32'hFFFF_FFFF);
    // show, one ms short of expiry, blocked extension, then expiry on the dot
    send_request(ACT_TICK,   SENSOR_SOIL,    1'b0, 1'b0, 32'd100);
    send_request(ACT_TICK,   SENSOR_SOIL,    1'b0, 1'b0, 32'd1599);
    send_request(ACT_TICK,   SENSOR_SOIL,    1'b0, 1'b1, 32'd1599);
    send_request(ACT_TICK,   SENSOR_SOIL,    1'b0, 1'b0, 32'd3098);
    send_request(ACT_TICK,   SENSOR_SOIL,    1'b0, 1'b0, 32'd3099);
    // soil disc left the queue, so it can be queued again
    send_request(ACT_SAMPLE, SENSOR_SOIL,    1'b0, 1'b0, 32'd0);
    // age of exactly half the time range reads as negative, one less as expired
    send_request(ACT_TICK,   SENSOR_SOIL,    1'b0, 1'b0, 32'h8000_11F7);
    send_request(ACT_TICK,   SENSOR_SOIL,    1'b0, 1'b0, 32'h8000_11F6);

    // --- directed, longest hold time, deadlines across the wrap ---
    settle();
    write_hold(16'hFFFF);
    send_request(ACT_TICK,   SENSOR_SOIL,    1'b0, 1'b0, 32'hFFFF_FFFF);
    send_request(ACT_TICK,   SENSOR_SOIL,    1'b0, 1'b1, 32'hFFFF_0000);
    send_request(ACT_TICK,   SENSOR_SOIL,    1'b0, 1'b0, 32'd0);
    send_request(ACT_TICK,   SENSOR_SOIL,    1'b0, 1'b0, 32'h0000_FFFE);

    // --- random: hold of 1 ms, sender mostly busy, receiver mostly stalled ---
    settle();
    write_hold(16'd1);
    clock_ms = $urandom;
    run_random_phase(PHASE_ITEMS);

    // --- random: longest hold, sides swapped ---
    settle();
    send_idle_pct = 79;
    recv_idle_pct = 9;
    write_hold(16'hFFFF);
    run_random_phase(PHASE_ITEMS);

    // --- random: mid-range hold, no idling at all ---
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_hold(HOLD_W'($urandom_range(2, 4000)));
    run_random_phase(PHASE_ITEMS);

    settle();
    if (mismatch_total == 0 && in_flight == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sllcn_pkg.sv
rtl/sllcn_ctrl.sv
rtl/sllcn_dpath.sv
rtl/sensor_link_change_notice_queue.sv
verif/link_notice_checker.sv
verif/testbench.sv
